FILE: src/auf_pkg.sv
// Package for the 128-bit UUID advertising field matcher.
// Holds field type codes, widths and the parser phase type; no dependencies.
`default_nettype none

package auf_pkg;

  // Number of leading UUID-list value bytes compared against the configured UUID
  localparam int unsigned UUID_BYTES = 16;
  localparam int unsigned POS_W      = $clog2(UUID_BYTES + 1);
  localparam int unsigned SEL_W      = (UUID_BYTES > 1) ? $clog2(UUID_BYTES) : 1;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CFG_W      = 64;
  localparam int unsigned CFG_IDX_W  = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_UUID_LOW  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_UUID_HIGH = 1'b1;

  // AD types for 128-bit service UUID lists
  localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_PARTIAL  = 8'h06;
  localparam logic [BYTE_W-1:0] AD_TYPE_UUID128_COMPLETE = 8'h07;

  // Parser phase, one-hot
  typedef enum logic [2:0] {
    PH_LENGTH = 3'b001,
    PH_TYPE   = 3'b010,
    PH_VALUE  = 3'b100
  } phase_t;

endpackage

`default_nettype wire

FILE: src/adv_uuid128_field_matcher_core.sv
// Top level of the 128-bit UUID advertising field matcher.
// Depends on auf_pkg for constants and the parser phase type.
`default_nettype none

// Usage:
//   The slave stream takes one advertising payload byte per word on s_tdata,
//   with s_tlast high on the final byte of the packet. The parser walks the
//   length-type-value fields and, for fields of type 0x06/0x07, compares the
//   first 16 value bytes with the UUID held in the two config registers.
//   Zero length bytes are padding; fields shorter than 16 value bytes, or cut
//   off by the packet end before the 16th value byte, never match.
//   Only the final byte of a packet yields a result word on the master
//   stream: m_tdata[0] is service_found. It appears in the cycle after the
//   final byte is taken, from a single output register.
//   Throughput is one byte per cycle: the parse state updates in the cycle a
//   byte is taken. s_tready is low only while a result waits in the output
//   register and m_tready is low, so a stall holds the input side until the
//   result is taken.
//   Config registers are written through cfg_we/cfg_index/cfg_data; the user
//   must write them only while the block is idle, which the block itself
//   does not enforce. An out-of-range index cannot occur with two registers.
//   Synchronous reset clears parse state, m_tvalid and both UUID registers.

module adv_uuid128_field_matcher_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // Input stream
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [auf_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] payload_byte
  input  wire logic                          s_tlast,   // last_byte
  // Result stream
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [auf_pkg::BYTE_W-1:0]         m_tdata,   // [0] service_found, [7:1] zero
  // Config write port
  input  wire logic                          cfg_we,
  input  wire logic [auf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [auf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int unsigned POS_W = auf_pkg::POS_W;
  localparam int unsigned SEL_W = auf_pkg::SEL_W;
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(auf_pkg::UUID_BYTES);

  // UUID registers
  logic [auf_pkg::CFG_W-1:0] uuid_low;
  logic [auf_pkg::CFG_W-1:0] uuid_high;
  logic [2*auf_pkg::CFG_W-1:0] uuid_all;

  // Parse state
  auf_pkg::phase_t            phase, phase_next;
  logic [auf_pkg::BYTE_W-1:0] bytes_left, bytes_left_next;
  logic [POS_W-1:0]           value_pos, value_pos_next;
  logic                       is_uuid_list, is_uuid_list_next;
  logic                       compare_ok, compare_ok_next;
  logic                       found, found_next;

  // Output register
  logic                       result;

  logic                       in_accept;
  logic [auf_pkg::BYTE_W-1:0] ref_byte;
  logic [POS_W-1:0]           pos_inc;
  logic [auf_pkg::BYTE_W-1:0] left_dec;

  assign s_tready  = !m_tvalid || m_tready;
  assign in_accept = s_tvalid && s_tready;
  assign m_tdata   = {{(auf_pkg::BYTE_W-1){1'b0}}, result};

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      uuid_low  <= '0;
      uuid_high <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        auf_pkg::REG_UUID_LOW:  uuid_low  <= cfg_data;
        auf_pkg::REG_UUID_HIGH: uuid_high <= cfg_data;
        default: ;
      endcase
    end
  end

  // Expected UUID byte at the current value position
  assign uuid_all = {uuid_high, uuid_low};
  assign ref_byte = uuid_all[{value_pos[SEL_W-1:0], 3'b000} +: auf_pkg::BYTE_W];
  assign pos_inc  = value_pos + POS_W'(1);
  assign left_dec = bytes_left - auf_pkg::BYTE_W'(1);

  // Field walk for one byte
  always_comb begin
    phase_next        = phase;
    bytes_left_next   = bytes_left;
    value_pos_next    = value_pos;
    is_uuid_list_next = is_uuid_list;
    compare_ok_next   = compare_ok;
    found_next        = found;
    unique case (phase)
      auf_pkg::PH_TYPE: begin
        is_uuid_list_next = (s_tdata == auf_pkg::AD_TYPE_UUID128_PARTIAL) ||
                            (s_tdata == auf_pkg::AD_TYPE_UUID128_COMPLETE);
        compare_ok_next   = 1'b1;
        value_pos_next    = '0;
        bytes_left_next   = left_dec;
        phase_next        = (left_dec == '0) ? auf_pkg::PH_LENGTH : auf_pkg::PH_VALUE;
      end
      auf_pkg::PH_VALUE: begin
        if (value_pos < POS_FULL) begin
          compare_ok_next = compare_ok && (s_tdata == ref_byte);
          value_pos_next  = pos_inc;
          if ((pos_inc == POS_FULL) && compare_ok_next && is_uuid_list) begin
            found_next = 1'b1;
          end
        end
        bytes_left_next = left_dec;
        if (left_dec == '0) begin
          phase_next = auf_pkg::PH_LENGTH;
        end
      end
      default: begin
        // length byte; zero is padding
        phase_next = auf_pkg::PH_LENGTH;
        if (s_tdata != '0) begin
          bytes_left_next = s_tdata;
          phase_next      = auf_pkg::PH_TYPE;
        end
      end
    endcase
  end

  // Parse state update; the final byte returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= auf_pkg::PH_LENGTH;
      bytes_left   <= '0;
      value_pos    <= '0;
      is_uuid_list <= 1'b0;
      compare_ok   <= 1'b0;
      found        <= 1'b0;
    end else if (in_accept) begin
      if (s_tlast) begin
        phase        <= auf_pkg::PH_LENGTH;
        bytes_left   <= '0;
        value_pos    <= '0;
        is_uuid_list <= 1'b0;
        compare_ok   <= 1'b0;
        found        <= 1'b0;
      end else begin
        phase        <= phase_next;
        bytes_left   <= bytes_left_next;
        value_pos    <= value_pos_next;
        is_uuid_list <= is_uuid_list_next;
        compare_ok   <= compare_ok_next;
        found        <= found_next;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (in_accept && s_tlast) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tlast) begin
      result <= found_next;
    end
  end

endmodule

`default_nettype wire

FILE: src/auf_checker.sv
// Port-level checker for the 128-bit UUID advertising field matcher.
// Bound to adv_uuid128_field_matcher_core; depends on auf_pkg for widths.
`default_nettype none

module auf_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          s_tvalid,
  input wire logic                          s_tready,
  input wire logic                          s_tlast,
  input wire logic                          m_tvalid,
  input wire logic                          m_tready,
  input wire logic [auf_pkg::BYTE_W-1:0]    m_tdata
);

  // A held result keeps its word
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result word changed while stalled");

  // Final byte of a packet yields a result next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> m_tvalid)
    else $error("no result after final byte");

  // A result only follows a final byte
  a_origin: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
    else $error("result without final byte");

  // Input is only blocked by a stalled result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input blocked without stalled result");

  // Padding bits of the result word stay zero
  a_pad: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[auf_pkg::BYTE_W-1:1] == '0))
    else $error("nonzero padding in result word");

endmodule

bind adv_uuid128_field_matcher_core auf_checker u_auf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
